@@ rtl/sce_pkg.sv @@
`timescale 1ns / 1ps
// sce_pkg: constants, register map and item layouts of the scene change estimator
// no dependencies; imported by scene_change_estimator_core
package sce_pkg;

    // detector and averaging
    localparam int unsigned WARMUP_FRAMES = 8;
    localparam int unsigned AVG_SHIFT     = 5;
    localparam int unsigned FRAMES_W      = 4;
    localparam logic [FRAMES_W-1:0] WARMUP_CNT = FRAMES_W'(WARMUP_FRAMES);
    localparam logic [FRAMES_W-1:0] FRAMES_CAP = FRAMES_W'(WARMUP_FRAMES + 1);

    // frame size is clipped so that size*1000 fits 32 bits
    localparam int unsigned SIZE_W   = 23;
    localparam logic [31:0] SIZE_CAP = 32'(32'hFFFF_FFFF / 1000);

    // divider
    localparam int unsigned DIV_W     = 32;
    localparam int unsigned DIV_CNT_W = 5;

    // result scaling
    localparam logic [15:0] BUDGET_NO_TARGET = 16'd1000;
    localparam logic [15:0] BUDGET_MAX       = 16'hFFFF;
    localparam logic [31:0] BUDGET_SCALE     = 32'd1000;
    localparam logic [7:0]  CPLX_MAX         = 8'hFF;
    localparam logic [31:0] CPLX_SCALE       = 32'd255;
    localparam logic [31:0] CPLX_DIVISOR     = 32'd1000;
    // complexity: full from a share of 1000, below that share*255/1000 by a
    // reciprocal multiply, 255 * ceil(2^28 / 1000), exact for shares under 1000
    localparam logic [15:0] CPLX_FULL_SHARE  = 16'd1000;
    localparam logic [26:0] CPLX_RECIP       = 27'd68451180;
    localparam int unsigned CPLX_RECIP_SHIFT = 28;

    // register map
    localparam int unsigned ADDR_W    = 4;
    localparam int unsigned REG_IDX_W = 2;
    localparam logic [REG_IDX_W-1:0] REG_INTRA_THR = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_TARGET    = 2'd2;
    localparam logic [15:0] THR_DEFAULT  = 16'd200;
    localparam logic [7:0]  HOLD_DEFAULT = 8'd2;

    // item kinds
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // input item payload, frame_bytes in the lowest bits
    typedef struct packed {
        logic [15:0] intra_share;
        logic [31:0] frame_bytes;
    } in_payload_t;

    // result item payload, complexity in the lowest bits, zero padded to 32 bits
    typedef struct packed {
        logic [6:0]  pad;
        logic [15:0] budget_pm;
        logic        cut_flag;
        logic [7:0]  complexity;
    } out_payload_t;

endpackage

@@ rtl/scene_change_estimator_core.sv @@
`timescale 1ns / 1ps
// scene_change_estimator_core: per-frame size average, complexity, budget ratio
// and scene change detection; depends on sce_pkg
//
// One item per encoded frame goes in on the s_ stream (tuser = command, clear or
// update) and one result item comes out on the m_ stream for each. The block works
// on one item at a time and drops s_tready until the item's result is registered.
// A frame update runs a setup step that also maps the intra share to the complexity
// by a reciprocal multiply, 32 steps of the restoring divider for the budget ratio,
// a spike test step and an output step that loads the output register. With the
// target register at zero the divider is skipped. The first frame only seeds the
// average and then goes to the output step, and so does a clear command.
// A finished result waits in an output register, so the next item is taken while
// the previous result is still pending; that item then waits in its output step
// until the register is free. Configuration goes through the APB port at byte
// addresses 0, 4 and 8; writing zero to the threshold or the holdoff restores its
// default.
module scene_change_estimator_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input items
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  sce_pkg::in_payload_t        s_tdata,   // [31:0] frame_bytes, [47:32] intra_share
    input  logic                        s_tuser,   // [0] cmd
    // result items
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output sce_pkg::out_payload_t       m_tdata,   // [7:0] complexity, [8] cut_flag,
                                                   // [24:9] budget_pm, [31:25] zero
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sce_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import sce_pkg::*;

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PREP  = 3'd1;
    localparam logic [2:0] ST_DIVB  = 3'd2;
    localparam logic [2:0] ST_SPIKE = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]           state_reg, state_next;

    // item being worked on
    logic [SIZE_W-1:0]    size_reg, size_next;
    logic [15:0]          intra_reg, intra_next;

    // estimator state
    logic [FRAMES_W-1:0]  frames_seen_reg, frames_seen_next;
    logic [31:0]          avg_reg, avg_next;
    logic [7:0]           spike_run_reg, spike_run_next;
    logic                 change_fired_reg, change_fired_next;
    logic [7:0]           last_cplx_reg, last_cplx_next;
    logic                 last_change_reg, last_change_next;
    logic [15:0]          last_budget_reg, last_budget_next;

    // divider
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W-1:0]     divisor_reg, divisor_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    out_payload_t         m_data_reg, m_data_next;

    // configuration registers
    logic [15:0]          thr_reg, thr_next;
    logic [7:0]           hold_reg, hold_next;
    logic [31:0]          target_reg, target_next;

    // divider datapath: one restoring step per cycle
    logic [DIV_W:0]       div_shift;
    logic [DIV_W:0]       div_diff;
    logic                 div_ge;
    logic [DIV_W-1:0]     div_rem_step;
    logic [DIV_W-1:0]     div_quo_step;
    logic                 div_last;

    // frame datapath
    logic [31:0]          size_q8;
    logic [31:0]          avg_up;
    logic [31:0]          avg_down;
    logic [23:0]          avg_int;
    logic [25:0]          avg_triple;
    logic                 spike;
    logic [7:0]           run_inc;
    logic                 out_free;
    logic [36:0]          cplx_prod;
    logic [7:0]           cplx_val;

    // configuration port
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;

    assign div_shift    = {rem_reg, quo_reg[DIV_W-1]};
    assign div_diff     = div_shift - {1'b0, divisor_reg};
    assign div_ge       = !div_diff[DIV_W];
    assign div_rem_step = div_ge ? div_diff[DIV_W-1:0] : div_shift[DIV_W-1:0];
    assign div_quo_step = {quo_reg[DIV_W-2:0], div_ge};
    assign div_last     = (cnt_reg == '1);

    // size with an 8-bit fraction, and the average moved 1/32 of the way to it
    assign size_q8    = 32'({size_reg, 8'h00});
    assign avg_up     = avg_reg + ((size_q8 - avg_reg) >> AVG_SHIFT);
    assign avg_down   = avg_reg - ((avg_reg - size_q8) >> AVG_SHIFT);

    // size*100/avg >= 300 is the same test as size >= 3*avg
    assign avg_int    = avg_reg[31:8];
    assign avg_triple = 26'({avg_int, 1'b0}) + 26'(avg_int);
    assign spike      = (frames_seen_reg > WARMUP_CNT) &&
                        ((intra_reg >= thr_reg) ||
                         ((avg_int != '0) && (26'(size_reg) >= avg_triple)));
    assign run_inc    = (spike_run_reg == 8'hFF) ? spike_run_reg : spike_run_reg + 8'd1;

    // intra share mapped to 0..255, full from a share of 1000 upwards
    assign cplx_prod  = 37'(intra_reg[9:0]) * 37'(CPLX_RECIP);
    assign cplx_val   = (intra_reg >= CPLX_FULL_SHARE) ? CPLX_MAX
                                                       : cplx_prod[CPLX_RECIP_SHIFT +: 8];

    assign out_free   = !m_valid_reg || m_tready;

    assign s_tready   = (state_reg == ST_IDLE);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // sequencer and datapath
    always_comb begin
        state_next        = state_reg;
        size_next         = size_reg;
        intra_next        = intra_reg;
        frames_seen_next  = frames_seen_reg;
        avg_next          = avg_reg;
        spike_run_next    = spike_run_reg;
        change_fired_next = change_fired_reg;
        last_cplx_next    = last_cplx_reg;
        last_change_next  = last_change_reg;
        last_budget_next  = last_budget_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        divisor_next      = divisor_reg;
        cnt_next          = cnt_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;

        // result taken downstream
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    size_next  = (s_tdata.frame_bytes > SIZE_CAP) ? SIZE_CAP[SIZE_W-1:0]
                                                                  : s_tdata.frame_bytes[SIZE_W-1:0];
                    intra_next = s_tdata.intra_share;
                    if (s_tuser == CMD_CLEAR) begin
                        // clear the detector and the reported flag, keep the average and the other results
                        spike_run_next    = '0;
                        change_fired_next = 1'b0;
                        last_change_next  = 1'b0;
                        state_next        = ST_OUT;
                    end else begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                frames_seen_next = (frames_seen_reg == FRAMES_CAP) ? frames_seen_reg
                                                                  : frames_seen_reg + 1'b1;
                rem_next = '0;
                cnt_next = '0;
                if (frames_seen_reg == '0) begin
                    // first frame seeds the average
                    avg_next         = size_q8;
                    last_cplx_next   = '0;
                    last_change_next = 1'b0;
                    last_budget_next = BUDGET_NO_TARGET;
                    state_next       = ST_OUT;
                end else begin
                    avg_next       = (size_q8 > avg_reg) ? avg_up : avg_down;
                    last_cplx_next = cplx_val;
                    if (target_reg != '0) begin
                        quo_next     = 32'(size_reg) * BUDGET_SCALE;
                        divisor_next = target_reg;
                        state_next   = ST_DIVB;
                    end else begin
                        last_budget_next = BUDGET_NO_TARGET;
                        state_next       = ST_SPIKE;
                    end
                end
            end
            ST_DIVB: begin
                rem_next = div_rem_step;
                quo_next = div_quo_step;
                cnt_next = cnt_reg + 1'b1;
                if (div_last) begin
                    last_budget_next = (div_quo_step[31:16] != '0) ? BUDGET_MAX
                                                                   : div_quo_step[15:0];
                    state_next       = ST_SPIKE;
                end
            end
            ST_SPIKE: begin
                if (spike) begin
                    spike_run_next = run_inc;
                    if ((run_inc >= hold_reg) && !change_fired_reg) begin
                        last_change_next  = 1'b1;
                        change_fired_next = 1'b1;
                    end
                end else begin
                    spike_run_next    = '0;
                    change_fired_next = 1'b0;
                    last_change_next  = 1'b0;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.pad        = '0;
                    m_data_next.budget_pm  = last_budget_reg;
                    m_data_next.cut_flag   = last_change_reg;
                    m_data_next.complexity = last_cplx_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // configuration writes and reads
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[ADDR_W-1:2];
    assign pready  = 1'b1;

    always_comb begin
        thr_next    = thr_reg;
        hold_next   = hold_reg;
        target_next = target_reg;
        if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INTRA_THR: thr_next  = (pwdata[15:0] == '0) ? THR_DEFAULT : pwdata[15:0];
                REG_HOLDOFF:   hold_next = (pwdata[7:0] == '0) ? HOLD_DEFAULT : pwdata[7:0];
                REG_TARGET:    target_next = pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INTRA_THR: prdata = 32'(thr_reg);
            REG_HOLDOFF:   prdata = 32'(hold_reg);
            REG_TARGET:    prdata = target_reg;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            frames_seen_reg  <= '0;
            avg_reg          <= '0;
            spike_run_reg    <= '0;
            change_fired_reg <= 1'b0;
            last_cplx_reg    <= '0;
            last_change_reg  <= 1'b0;
            last_budget_reg  <= '0;
            m_valid_reg      <= 1'b0;
            thr_reg          <= THR_DEFAULT;
            hold_reg         <= HOLD_DEFAULT;
            target_reg       <= '0;
        end else begin
            state_reg        <= state_next;
            frames_seen_reg  <= frames_seen_next;
            avg_reg          <= avg_next;
            spike_run_reg    <= spike_run_next;
            change_fired_reg <= change_fired_next;
            last_cplx_reg    <= last_cplx_next;
            last_change_reg  <= last_change_next;
            last_budget_reg  <= last_budget_next;
            m_valid_reg      <= m_valid_next;
            thr_reg          <= thr_next;
            hold_reg         <= hold_next;
            target_reg       <= target_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        size_reg    <= size_next;
        intra_reg   <= intra_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
        cnt_reg     <= cnt_next;
        m_data_reg  <= m_data_next;
    end

    // frame counter never runs past its cap
    a_frames_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        frames_seen_reg <= FRAMES_CAP)
        else $error("frame counter past cap");

    // a fired change always belongs to a live spike run
    a_fired_run: assert property (@(posedge aclk) disable iff (!aresetn)
        change_fired_reg |-> (spike_run_reg != '0))
        else $error("change fired without spike run");

    // the reported flag is only up while the detector is latched
    a_change_fired: assert property (@(posedge aclk) disable iff (!aresetn)
        last_change_reg |-> change_fired_reg)
        else $error("scene change reported without fired detector");

    // an accepted item closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened in cycle after accept");

    // divider runs start with a cleared remainder and count
    a_div_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_PREP) && (frames_seen_reg != '0)) |=>
            ((rem_reg == '0) && (cnt_reg == '0)))
        else $error("divider not reset at start of run");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for scene_change_estimator_core, with its own
// behavioural predictor of the estimator; depends on sce_pkg and the core only
module testbench;
    import sce_pkg::*;

    // spike test on frame size: size must reach 300 percent of the average
    localparam int unsigned SPIKE_PCT_SCALE = 100;
    localparam int unsigned SPIKE_PCT_MIN   = 300;
    // register slot with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int unsigned PHASES        = 7;
    localparam int unsigned TINY_PHASE    = 1;
    localparam int unsigned PHASE_ITEMS   = 140;
    localparam int unsigned TINY_ITEMS    = 500;
    localparam int unsigned LONG_HOLD     = 500;
    localparam int unsigned HOLD_AT_FIRST = 150;
    localparam int unsigned HOLD_AT_LATER = 900;
    localparam int unsigned TAIL_CYCLES   = 100;
    localparam int unsigned LIMIT_NS      = 2_000_000;

    typedef struct packed {
        logic [7:0]  complexity;
        logic        cut_flag;
        logic [15:0] budget_pm;
    } estimate_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // one line of the directed part: an item or a register write
    typedef struct packed {
        row_kind_t              kind;
        logic                   cmd;
        logic [31:0]            bytes;
        logic [15:0]            intra;
        logic                   typed;
        estimate_t              want;
        logic [REG_IDX_W-1:0]   idx;
        logic [31:0]            value;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    in_payload_t          s_tdata = '0;
    logic                 s_tuser = CMD_UPDATE;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    out_payload_t         m_tdata;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [ADDR_W-1:0]    paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    scene_change_estimator_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 aclk = ~aclk;

    // shadow of the register file
    logic [15:0] cfg_thr = THR_DEFAULT;
    logic [7:0]  cfg_hold = HOLD_DEFAULT;
    logic [31:0] cfg_target = '0;

    // predictor state
    logic [FRAMES_W-1:0] seen_frames = '0;
    logic [31:0]         avg_fp8 = '0;
    logic [7:0]          spike_len = '0;
    logic                change_latched = 1'b0;
    estimate_t           last_est = '0;

    estimate_t  pending_est[$];
    dir_row_t   dir_rows[$];
    int         n_errors = 0;
    int         sent_count = 0;
    bit         send_eager = 1'b0;
    // typed expectation travelling with the item on offer
    logic       row_typed = 1'b0;
    estimate_t  row_want = '0;

    // next estimate of the block for one accepted item
    function automatic estimate_t estimate_frame(input logic cmd, input logic [31:0] bytes,
                                                 input logic [15:0] intra);
        logic [31:0] size;
        logic [31:0] size_q8;
        logic [31:0] budget;
        logic [31:0] cplx;
        logic [31:0] avg;
        logic        spike;
        if (cmd == CMD_CLEAR) begin
            // clear touches the detector and the cut flag, the rest of the estimate stays
            spike_len = '0;
            change_latched = 1'b0;
            last_est.cut_flag = 1'b0;
        end else begin
            size = (bytes > SIZE_CAP) ? SIZE_CAP : bytes;
            size_q8 = size << 8;
            if (seen_frames < FRAMES_CAP)
                seen_frames++;
            if (seen_frames == 1) begin
                // first frame seeds the average; the estimate gets zero complexity, no cut, no-target budget
                avg_fp8 = size_q8;
                last_est = '{complexity: '0, cut_flag: 1'b0,
                             budget_pm: BUDGET_NO_TARGET};
            end else begin
                if (size_q8 > avg_fp8)
                    avg_fp8 = avg_fp8 + ((size_q8 - avg_fp8) >> AVG_SHIFT);
                else
                    avg_fp8 = avg_fp8 - ((avg_fp8 - size_q8) >> AVG_SHIFT);

                if (cfg_target != 0)
                    budget = (size * BUDGET_SCALE) / cfg_target;
                else
                    budget = 32'(BUDGET_NO_TARGET);
                if (budget > 32'(BUDGET_MAX))
                    budget = 32'(BUDGET_MAX);

                cplx = (32'(intra) * CPLX_SCALE) / CPLX_DIVISOR;
                if (cplx > 32'(CPLX_MAX))
                    cplx = 32'(CPLX_MAX);

                last_est.complexity = cplx[7:0];
                last_est.budget_pm = budget[15:0];

                spike = 1'b0;
                if (seen_frames > WARMUP_CNT) begin
                    avg = avg_fp8 >> 8;
                    if (intra >= cfg_thr)
                        spike = 1'b1;
                    else if (avg != 0 && (size * SPIKE_PCT_SCALE) / avg >= SPIKE_PCT_MIN)
                        spike = 1'b1;
                end

                if (spike) begin
                    if (spike_len != 8'hFF)
                        spike_len++;
                    if (spike_len >= cfg_hold && !change_latched) begin
                        last_est.cut_flag = 1'b1;
                        change_latched = 1'b1;
                    end
                end else begin
                    spike_len = '0;
                    change_latched = 1'b0;
                    last_est.cut_flag = 1'b0;
                end
            end
        end
        return last_est;
    endfunction

    function automatic void shadow_write(input logic [REG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
        case (idx)
            REG_INTRA_THR: cfg_thr = (value[15:0] != 0) ? value[15:0] : THR_DEFAULT;
            REG_HOLDOFF:   cfg_hold = (value[7:0] != 0) ? value[7:0] : HOLD_DEFAULT;
            REG_TARGET:    cfg_target = value;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] shadow_read(input logic [REG_IDX_W-1:0] idx);
        case (idx)
            REG_INTRA_THR: return 32'(cfg_thr);
            REG_HOLDOFF:   return 32'(cfg_hold);
            REG_TARGET:    return cfg_target;
            default:       return '0;
        endcase
    endfunction

    function automatic void check_field(input string name, input longint unsigned want,
                                        input longint unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            n_errors++;
        end
    endfunction

    // row builders for the directed part
    function automatic dir_row_t item_row(input logic cmd, input logic [31:0] bytes,
                                          input logic [15:0] intra);
        dir_row_t r;
        r = '0;
        r.kind = ROW_ITEM;
        r.cmd = cmd;
        r.bytes = bytes;
        r.intra = intra;
        return r;
    endfunction

    function automatic dir_row_t typed_row(input logic cmd, input logic [31:0] bytes,
                                           input logic [15:0] intra, input estimate_t want);
        dir_row_t r;
        r = item_row(cmd, bytes, intra);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic dir_row_t cfg_row(input logic [REG_IDX_W-1:0] idx,
                                         input logic [31:0] value);
        dir_row_t r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.value = value;
        return r;
    endfunction

    // one apb transfer: setup phase, then access phase
    task automatic apb_xfer(input logic write, input logic [REG_IDX_W-1:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge aclk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = write;
        paddr = ADDR_W'({idx, 2'b00});
        pwdata = wdata;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        if (write)
            shadow_write(idx, wdata);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // read back every register and compare with the shadow
    task automatic check_registers();
        logic [31:0] rd;
        for (int r = REG_INTRA_THR; r <= REG_TARGET; r++) begin
            apb_xfer(1'b0, REG_IDX_W'(r), '0, rd);
            check_field($sformatf("register %0d", r), shadow_read(REG_IDX_W'(r)), rd);
        end
    endtask

    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] rd;
        apb_xfer(1'b1, idx, value, rd);
        check_registers();
    endtask

    // stop offering items and wait until every estimate has come back
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_est.size() != 0)
            @(negedge aclk);
    endtask

    // offer one item after a random gap and hold it until taken
    task automatic send_item(input logic cmd, input logic [31:0] bytes, input logic [15:0] intra,
                             input logic typed, input estimate_t want);
        int gap;
        if (sent_count % 32 == 0)
            send_eager = ($urandom_range(0, 3) == 0);
        gap = send_eager ? 0 : $urandom_range(0, 9);
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser = cmd;
        s_tdata.frame_bytes = bytes;
        s_tdata.intra_share = intra;
        row_typed = typed;
        row_want = want;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // accepted items feed the predictor, accepted results are checked in order
    always @(posedge aclk) begin : scoreboard
        estimate_t pred;
        estimate_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                pred = estimate_frame(s_tuser, s_tdata.frame_bytes, s_tdata.intra_share);
                pending_est.push_back(row_typed ? row_want : pred);
            end
            if (m_tvalid && m_tready) begin
                if (pending_est.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual %h",
                             $time, m_tdata);
                    n_errors++;
                end else begin
                    want = pending_est.pop_front();
                    check_field("complexity", want.complexity, m_tdata.complexity);
                    check_field("cut_flag", want.cut_flag, m_tdata.cut_flag);
                    check_field("budget_pm", want.budget_pm, m_tdata.budget_pm);
                    check_field("padding", 0, m_tdata.pad);
                end
            end
        end
    end

    // result side: random stalls, eager stretches and two long hold-offs
    initial begin : result_sink
        int stall;
        int taken;
        bit eager;
        taken = 0;
        eager = 1'b0;
        while (!aresetn)
            @(negedge aclk);
        forever begin
            @(negedge aclk);
            if (taken % 40 == 0)
                eager = ($urandom_range(0, 3) == 0);
            stall = eager ? 0 : $urandom_range(0, 9);
            // long hold-off so the output register fills and the input stalls
            if (taken == HOLD_AT_FIRST || taken == HOLD_AT_LATER)
                stall = LONG_HOLD;
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            taken++;
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        dir_row_t    row;
        int unsigned base;
        int unsigned lim;
        int unsigned roll;
        int unsigned n_items;
        int          burst_left;
        logic [31:0] bytes;
        logic [15:0] intra;
        logic [31:0] thr_v;
        logic [31:0] hold_v;
        logic [31:0] target_v;

        // directed part; typed rows read straight off the spec
        dir_rows.push_back(typed_row(CMD_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, '0));
        dir_rows.push_back(typed_row(CMD_UPDATE, 32'hFFFF_FFFF, 16'hFFFF,
                           '{complexity: '0, cut_flag: 1'b0, budget_pm: BUDGET_NO_TARGET}));
        dir_rows.push_back(typed_row(CMD_UPDATE, 32'd0, 16'd0,
                           '{complexity: '0, cut_flag: 1'b0, budget_pm: BUDGET_NO_TARGET}));
        dir_rows.push_back(typed_row(CMD_UPDATE, 32'd100, 16'hFFFF,
                           '{complexity: CPLX_MAX, cut_flag: 1'b0,
                             budget_pm: BUDGET_NO_TARGET}));
        dir_rows.push_back(typed_row(CMD_UPDATE, 32'd100, 16'd1000,
                           '{complexity: CPLX_MAX, cut_flag: 1'b0,
                             budget_pm: BUDGET_NO_TARGET}));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd999));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd4));
        // size exactly at the clip, then one above it
        dir_rows.push_back(item_row(CMD_UPDATE, SIZE_CAP, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, SIZE_CAP + 1, 16'd0));
        // warm-up over from here on
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd200));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'hFFFF));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd300));
        dir_rows.push_back(item_row(CMD_CLEAR, 32'd0, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd250));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd100, 16'd199));
        // zero restores the defaults, the spare slot must be ignored
        dir_rows.push_back(cfg_row(REG_INTRA_THR, 32'd0));
        dir_rows.push_back(cfg_row(REG_HOLDOFF, 32'd0));
        dir_rows.push_back(cfg_row(REG_TARGET, 32'd1));
        dir_rows.push_back(cfg_row(REG_SPARE, 32'hFFFF_FFFF));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'hFFFF_FFFF, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd1, 16'd0));
        dir_rows.push_back(cfg_row(REG_TARGET, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_INTRA_THR, 32'd1));
        dir_rows.push_back(cfg_row(REG_HOLDOFF, 32'd1));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd0, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd0, 16'd1));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd5000000, 16'd0));
        dir_rows.push_back(item_row(CMD_UPDATE, 32'd1000, 16'd0));
        dir_rows.push_back(cfg_row(REG_INTRA_THR, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_HOLDOFF, 32'hFFFF_FFFF));
        dir_rows.push_back(cfg_row(REG_TARGET, SIZE_CAP));
        dir_rows.push_back(item_row(CMD_UPDATE, SIZE_CAP, 16'hFFFE));
        dir_rows.push_back(item_row(CMD_UPDATE, SIZE_CAP, 16'hFFFF));

        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        check_registers();

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == ROW_CFG) begin
                settle();
                write_register(row.idx, row.value);
            end else begin
                send_item(row.cmd, row.bytes, row.intra, row.typed, row.want);
            end
        end

        // random part: one register setting per phase, frames around a base size
        // with bursts of spikes about as long as the holdoff
        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == 0) begin
                thr_v = 32'd1;
                hold_v = 32'd1;
                target_v = 32'd1;
            end else if (phase == TINY_PHASE) begin
                thr_v = 32'hFFFF;
                hold_v = 32'hFF;
                target_v = 32'hFFFF_FFFF;
            end else begin
                case ($urandom_range(0, 2))
                    0:       thr_v = 32'd0;
                    1:       thr_v = $urandom_range(50, 900);
                    default: thr_v = $urandom_range(1, 65535);
                endcase
                hold_v = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom_range(1, 6);
                case ($urandom_range(0, 2))
                    0:       target_v = 32'd0;
                    1:       target_v = $urandom_range(1000, 1000000);
                    default: target_v = $urandom;
                endcase
            end
            settle();
            write_register(REG_INTRA_THR, thr_v);
            write_register(REG_HOLDOFF, hold_v);
            write_register(REG_TARGET, target_v);

            // tiny frames drive the average down to zero
            base = (phase == TINY_PHASE) ? $urandom_range(0, 2) : $urandom_range(500, 200000);
            n_items = (phase == TINY_PHASE) ? TINY_ITEMS : PHASE_ITEMS;
            burst_left = 0;
            for (int unsigned n = 0; n < n_items; n++) begin
                roll = $urandom_range(0, 99);
                lim = (cfg_thr > 16'd1000) ? 1000 : int'(cfg_thr) - 1;
                if (roll < 6) begin
                    send_item(CMD_CLEAR, $urandom, 16'($urandom), 1'b0, '0);
                end else if (roll < 12) begin
                    // noise over the full field range, kept small in the tiny phase
                    bytes = (base >= 500) ? $urandom : $urandom_range(0, 2);
                    send_item(CMD_UPDATE, bytes, 16'($urandom), 1'b0, '0);
                end else if (burst_left > 0) begin
                    burst_left--;
                    if (base >= 500 && $urandom_range(0, 1) == 1) begin
                        bytes = base * 4 + $urandom_range(0, base);
                        intra = 16'($urandom_range(0, lim));
                    end else begin
                        bytes = base + $urandom_range(0, base / 4);
                        intra = 16'($urandom_range(int'(cfg_thr), 65535));
                    end
                    send_item(CMD_UPDATE, bytes, intra, 1'b0, '0);
                end else begin
                    bytes = base + $urandom_range(0, base / 4);
                    intra = 16'($urandom_range(0, lim));
                    send_item(CMD_UPDATE, bytes, intra, 1'b0, '0);
                    if ($urandom_range(0, 9) == 0)
                        burst_left = int'(cfg_hold) + $urandom_range(0, 2) - 1;
                end
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (n_errors == 0 && pending_est.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
